// ===== rtl/midi_voice_allocator_top_macros.svh =====
// Assertion macros shared by the voice allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MIDI_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mva_pkg.sv =====
// Shared types and constants for the MIDI voice allocator.
// No dependencies; used by every other RTL file except the assertion macros header.
package mva_pkg;

    // Fixed field widths.
    localparam int STATUS_W    = 8;
    localparam int NOTE_W      = 7;
    localparam int CHAN_W      = 4;
    localparam int CODE_W      = 9;
    localparam int ACTION_W    = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int CHAN_SLOTS  = 16;
    localparam int NOTE_COUNT  = 128;
    localparam int VOICE_CNT_W = 5;

    // Parameter defaults.
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_VOICES_DEF   = 4;

    // MIDI status codes.
    localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'd128;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'd144;

    // Note code for a note-off.
    localparam logic signed [CODE_W-1:0] CODE_OFF = -9'sd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_MODE    = 1'b1;

    // Edit modes.
    localparam logic [MODE_W-1:0] EDIT_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] EDIT_RECORD = 2'd1;

    // Pattern write actions.
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd2;

    // Operations of the shared channel step unit.
    typedef enum logic [0:0] {
        STEP_REDUCE  = 1'b0,
        STEP_ADVANCE = 1'b1
    } step_op_t;

    // Write command into the note-to-channel map.
    typedef struct packed {
        logic              en;
        logic              mapped;
        logic [NOTE_W-1:0] note;
        logic [CHAN_W-1:0] chan;
    } note_map_wr_t;

endpackage

// ===== rtl/mva_interfaces.sv =====
// Valid/ready channel interfaces for note events and results.
// Depends on mva_pkg for the field widths.
interface mva_in_if;
    logic                              valid;
    logic                              ready;
    logic [mva_pkg::STATUS_W-1:0]      status_byte;
    logic [mva_pkg::NOTE_W-1:0]        note_number;

    modport source (output valid, status_byte, note_number, input ready);
    modport sink   (input valid, status_byte, note_number, output ready);
endinterface

interface mva_out_if;
    logic                              valid;
    logic                              ready;
    logic [mva_pkg::CHAN_W-1:0]        play_channel;
    logic signed [mva_pkg::CODE_W-1:0] note_code;
    logic [mva_pkg::ACTION_W-1:0]      write_action;

    modport source (output valid, play_channel, note_code, write_action, input ready);
    modport sink   (input valid, play_channel, note_code, write_action, output ready);
endinterface

// ===== rtl/mva_step_unit.sv =====
// Shared channel arithmetic: modulo reduction and wrapping increment.
// Depends on mva_pkg.
module mva_step_unit #(
    parameter int NUM_CHANNELS = mva_pkg::NUM_CHANNELS_DEF
) (
    input  mva_pkg::step_op_t          op,
    input  logic [mva_pkg::CHAN_W-1:0] value,
    output logic [mva_pkg::CHAN_W-1:0] result,
    output logic                       wrapped
);
    import mva_pkg::*;

    localparam logic [CHAN_W:0] NUM_CH = (CHAN_W+1)'(NUM_CHANNELS);

    logic [CHAN_W:0] sum;

    // One add and one compare-subtract against the channel count.
    always_comb
    begin
        sum     = {1'b0, value} + ((op == STEP_ADVANCE) ? (CHAN_W+1)'(1) : '0);
        wrapped = (sum >= NUM_CH);
        result  = wrapped ? CHAN_W'(sum - NUM_CH) : sum[CHAN_W-1:0];
    end
endmodule

// ===== rtl/mva_note_map.sv =====
// Note-to-channel map: mapped flags in flip-flops, channels in a memory.
// Depends on mva_pkg.
module mva_note_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mva_pkg::note_map_wr_t       wr,
    input  logic [mva_pkg::NOTE_W-1:0]  rd_note,
    output logic                        rd_mapped,
    output logic [mva_pkg::CHAN_W-1:0]  rd_chan
);
    import mva_pkg::*;

    logic [NOTE_COUNT-1:0] mapped_reg;
    logic [CHAN_W-1:0]     chan_mem [NOTE_COUNT];
    logic [CHAN_W-1:0]     rd_chan_reg;

    // Mapped flags clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg <= '0;
        end
        else if (wr.en)
        begin
            mapped_reg[wr.note] <= wr.mapped;
        end
    end

    // Channel memory is written only when a note gets mapped.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.mapped)
        begin
            chan_mem[wr.note] <= wr.chan;
        end
        rd_chan_reg <= chan_mem[rd_note];
    end

    assign rd_mapped = mapped_reg[rd_note];
    assign rd_chan   = rd_chan_reg;
endmodule

// ===== rtl/midi_voice_allocator_top.sv =====
// Flow: a note-on reduces base_channel by NUM_CHANNELS, searches for a free channel
// (at most MAX_VOICES-1 search steps), steals and maps, then loads its output word.
// A note-off reads the note map, then unmaps and releases; unmapped notes give no word.
// Throughput: one word at a time; a new word is taken only when the sequencer is idle.
// Reset: asynchronous active-low; clears all note mappings and busy channels,
// sets base_channel and edit_mode to 0, and empties the output register.
module midi_voice_allocator_top #(
    parameter int NUM_CHANNELS = mva_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_VOICES   = mva_pkg::MAX_VOICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mva_in_if.sink                          note_in,
    mva_out_if.source                       note_out,
    input  logic                            cfg_we,
    input  logic [mva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mva_pkg::*;

`include "midi_voice_allocator_top_macros.svh"

    localparam logic [VOICE_CNT_W-1:0] MAX_V = VOICE_CNT_W'(MAX_VOICES);
    localparam logic [CHAN_W:0]        NUM_CH = (CHAN_W+1)'(NUM_CHANNELS);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_ON_MOD   = 8'b0000_0010,
        ST_ON_SRCH  = 8'b0000_0100,
        ST_ON_STEAL = 8'b0000_1000,
        ST_ON_MAP   = 8'b0001_0000,
        ST_OFF_RD   = 8'b0010_0000,
        ST_OFF_DO   = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CHAN_W-1:0]         base_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [NOTE_W-1:0]         note_reg, note_next;
    logic [CHAN_W-1:0]         chan_reg, chan_next;
    logic [VOICE_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CHAN_SLOTS-1:0]     busy_reg, busy_next;
    logic [NOTE_W-1:0]         chan_note_reg [CHAN_SLOTS];
    logic                      chan_note_we;
    logic signed [CODE_W-1:0]  code_reg, code_next;
    logic [ACTION_W-1:0]       act_reg, act_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]         out_chan_reg;
    logic signed [CODE_W-1:0]  out_code_reg;
    logic [ACTION_W-1:0]       out_act_reg;
    logic                      out_load;

    step_op_t                  step_op;
    logic [CHAN_W-1:0]         step_result;
    logic                      step_wrapped;
    note_map_wr_t              map_wr;
    logic                      map_mapped;
    logic [CHAN_W-1:0]         map_chan;
    logic                      accept;
    logic [CHAN_SLOTS-1:0]     free_mask;

    // Shared channel arithmetic.
    mva_step_unit #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_step (
        .op      (step_op),
        .value   (chan_reg),
        .result  (step_result),
        .wrapped (step_wrapped)
    );

    // Note-to-channel map.
    mva_note_map u_note_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (map_wr),
        .rd_note   (note_reg),
        .rd_mapped (map_mapped),
        .rd_chan   (map_chan)
    );

    assign note_in.ready = (state_reg == ST_IDLE);
    assign accept        = note_in.valid && note_in.ready;
    assign step_op       = (state_reg == ST_ON_MOD) ? STEP_REDUCE : STEP_ADVANCE;
    assign free_mask     = ~(CHAN_SLOTS'(1) << map_chan);

    // Sequencer: modulo start, free-channel search, steal, map, and release.
    always_comb
    begin
        state_next   = state_reg;
        note_next    = note_reg;
        chan_next    = chan_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        code_next    = code_reg;
        act_next     = act_reg;
        chan_note_we = 1'b0;
        map_wr       = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    note_next = note_in.note_number;
                    chan_next = base_reg;
                    if (note_in.status_byte == STATUS_NOTE_ON)
                    begin
                        state_next = ST_ON_MOD;
                    end
                    else if (note_in.status_byte == STATUS_NOTE_OFF)
                    begin
                        state_next = ST_OFF_RD;
                    end
                end
            end
            ST_ON_MOD:
            begin
                if (step_wrapped)
                begin
                    chan_next = step_result;
                end
                else
                begin
                    cnt_next   = VOICE_CNT_W'(1);
                    state_next = ST_ON_SRCH;
                end
            end
            ST_ON_SRCH:
            begin
                if ((cnt_reg < MAX_V) && busy_reg[chan_reg])
                begin
                    chan_next = step_result;
                    cnt_next  = cnt_reg + VOICE_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_ON_STEAL;
                end
            end
            ST_ON_STEAL:
            begin
                // Unmap the note that loses its channel.
                if (busy_reg[chan_reg])
                begin
                    map_wr.en     = 1'b1;
                    map_wr.mapped = 1'b0;
                    map_wr.note   = chan_note_reg[chan_reg];
                end
                state_next = ST_ON_MAP;
            end
            ST_ON_MAP:
            begin
                busy_next[chan_reg] = 1'b1;
                chan_note_we        = 1'b1;
                map_wr.en           = 1'b1;
                map_wr.mapped       = 1'b1;
                map_wr.note         = note_reg;
                map_wr.chan         = chan_reg;
                code_next           = $signed({2'b00, note_reg} + CODE_W'(1));
                if (mode_reg == EDIT_NORMAL)
                begin
                    act_next = ACT_SET;
                end
                else if (mode_reg == EDIT_RECORD)
                begin
                    act_next = ACT_RECORD;
                end
                else
                begin
                    act_next = ACT_NONE;
                end
                state_next = ST_DONE;
            end
            ST_OFF_RD:
            begin
                state_next = ST_OFF_DO;
            end
            ST_OFF_DO:
            begin
                if (map_mapped)
                begin
                    chan_next           = map_chan;
                    busy_next[map_chan] = 1'b0;
                    map_wr.en           = 1'b1;
                    map_wr.mapped       = 1'b0;
                    map_wr.note         = note_reg;
                    code_next           = CODE_OFF;
                    if ((mode_reg == EDIT_RECORD) && ((busy_reg & free_mask) == '0))
                    begin
                        act_next = ACT_RECORD;
                    end
                    else
                    begin
                        act_next = ACT_NONE;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || note_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !note_out.ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            mode_reg      <= EDIT_NORMAL;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_CHANNEL: base_reg <= cfg_data[CHAN_W-1:0];
                    CFG_EDIT_MODE:    mode_reg <= cfg_data[MODE_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        chan_reg <= chan_next;
        code_reg <= code_next;
        act_reg  <= act_next;
        if (chan_note_we)
        begin
            chan_note_reg[chan_reg] <= note_reg;
        end
        if (out_load)
        begin
            out_chan_reg <= chan_reg;
            out_code_reg <= code_reg;
            out_act_reg  <= act_reg;
        end
    end

    assign note_out.valid        = out_valid_reg;
    assign note_out.play_channel = out_chan_reg;
    assign note_out.note_code    = out_code_reg;
    assign note_out.write_action = out_act_reg;

    // The search always looks at a channel below the channel count.
    `MVA_ASSERT_NOW(a_srch_chan_range, clk, rst_n, (state_reg == ST_ON_SRCH), ({1'b0, chan_reg} < NUM_CH), "search channel out of range")
    // The search never takes more than MAX_VOICES-1 steps.
    `MVA_ASSERT_NOW(a_srch_steps, clk, rst_n, (state_reg == ST_ON_SRCH), (cnt_reg <= MAX_V), "search step count overran")
    // A mapped note-on leaves its channel busy.
    `MVA_ASSERT_NEXT(a_map_busy, clk, rst_n, (state_reg == ST_ON_MAP), (busy_reg[$past(chan_reg)]), "mapped channel not busy")
    // A waiting result is never overwritten.
    `MVA_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid_reg && !note_out.ready), (out_valid_reg && $stable(out_code_reg)), "pending result lost")
endmodule
